>>> hw/rtl/gyro_bias_deadband_tracker_assert.svh
// assertion macros for the gyro bias deadband tracker
// used by gyro_bias_deadband_tracker.sv, no other dependencies
`ifndef GYRO_BIAS_DEADBAND_TRACKER_ASSERT_SVH
`define GYRO_BIAS_DEADBAND_TRACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define GBDT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GBDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBDT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define GBDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/gbdt_pkg.sv
// shared types and constants for the gyro bias deadband tracker
// no dependencies; used by the channel interfaces and the top level
package gbdt_pkg;

	localparam int CAL_SAMPLES = 100;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 16;
	localparam int RATE_W   = 25;
	localparam int BIAS_W   = 24;
	localparam int SUM_W    = 24;
	localparam int CNT_W    = 8;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = CFG_W + BIAS_W + 2;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic        [CFG_W-1:0]    cfg_t;
	typedef logic signed [RATE_W-1:0]   rate_t;
	typedef logic signed [BIAS_W-1:0]   bias_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic        [CNT_W-1:0]    cnt_t;
	typedef logic        [1:0]          cfg_idx_t;

	// register indexes
	localparam cfg_idx_t REG_BAND   = 2'd0;
	localparam cfg_idx_t REG_WEIGHT = 2'd1;
	localparam cfg_idx_t REG_SCALE  = 2'd2;

	localparam cfg_t BAND_RST   = 16'd50;
	localparam cfg_t WEIGHT_RST = 16'd655;
	localparam cfg_t SCALE_RST  = 16'd500;

	// rounded mean by reciprocal multiply, exact for any 32-bit dividend
	localparam int DIV_X_W = SUM_W + 8;
	localparam int DIV_K   = DIV_X_W + $clog2(CAL_SAMPLES);
	localparam int DIV_M_W = DIV_K - $clog2(CAL_SAMPLES) + 1;
	localparam int DIV_P_W = DIV_X_W + DIV_M_W;
	localparam logic [DIV_M_W-1:0] DIV_M =
		DIV_M_W'(((64'd1 << DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

endpackage

>>> hw/rtl/gbdt_if.sv
// channel interfaces: gyro sample in, result out, register write
// depends on gbdt_pkg
interface gbdt_sample_if;
	import gbdt_pkg::*;
	logic    valid;
	logic    ready;
	sample_t raw_sample;
	modport source(output valid, output raw_sample, input ready);
	modport sink(input valid, input raw_sample, output ready);
endinterface

interface gbdt_result_if;
	import gbdt_pkg::*;
	logic  valid;
	logic  ready;
	rate_t yaw_rate;
	logic  held_zero;
	logic  calibrating;
	bias_t bias_estimate;
	modport source(output valid, output yaw_rate, output held_zero, output calibrating,
		output bias_estimate, input ready);
	modport sink(input valid, input yaw_rate, input held_zero, input calibrating,
		input bias_estimate, output ready);
endinterface

interface gbdt_cfg_if;
	import gbdt_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cfg_t     data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/gyro_bias_deadband_tracker.sv
// gyro bias deadband tracker: calibration average, deadband bias tracking, rate scaling
// depends on gbdt_pkg, gbdt_if.sv and gyro_bias_deadband_tracker_assert.svh
//
// channel  role    handshake    payload
// sample   sink    valid/ready  raw_sample
// result   source  valid/ready  yaw_rate, held_zero, calibrating, bias_estimate
// cfg      sink    valid/ready  index, data (ready always high)
//
// one sample per cycle while the result is not stalled and no mean is pending:
// input register, logic, output register; the final calibration sample also waits
// in a mean step (fin_q) for the reciprocal multiply that forms the mean
// sample.ready drops only while the input register is held by a stalled result
// or by that mean step
// arst_n clears the pipeline valids, the calibration count and sum and the bias, and loads register defaults
`include "gyro_bias_deadband_tracker_assert.svh"

module gyro_bias_deadband_tracker (
	input logic         clk,
	input logic         arst_n,
	gbdt_cfg_if.sink    cfg,
	gbdt_sample_if.sink sample,
	gbdt_result_if.source result
);
	import gbdt_pkg::*;

	localparam cnt_t CAL_DONE = CNT_W'(CAL_SAMPLES);
	localparam cnt_t CAL_LAST = CNT_W'(CAL_SAMPLES - 1);
	localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(2 ** (FRAC_W - 1));
	localparam logic signed [PROD_W-1:0] RATE_HI = PROD_W'(2 ** (RATE_W - 1) - 1);
	localparam logic signed [PROD_W-1:0] RATE_LO = -RATE_HI - PROD_W'(1);

	cfg_t    band_q, weight_q, scale_q;
	logic    s1_v;
	sample_t smp_s1;
	logic    fin_q;
	cnt_t    cal_cnt_q;
	sum_t    cal_sum_q;
	bias_t   bias_q;
	logic    o_v_q;
	rate_t   o_rate_q;
	logic    o_held_q;
	logic    o_cal_q;
	bias_t   o_bias_q;

	logic out_free, cal_phase, cal_last, s1_go, o_load;
	sum_t sum_next;
	logic signed [BIAS_W-1:0] s8;
	logic signed [BIAS_W:0]   d;
	logic signed [BIAS_W+1:0] d_x, bw;
	logic in_band;
	logic signed [PROD_W-1:0] ema_p, ema_sh, rate_p, rate_sh;
	logic signed [BIAS_W:0]   bias_sum;
	bias_t bias_trk, bias_cal;
	rate_t rate_sat;
	logic               sum_neg;
	logic [SUM_W-1:0]   sum_mag;
	logic [DIV_X_W-1:0] div_x;
	logic [DIV_P_W-1:0] div_p;
	logic [BIAS_W-1:0]  div_q;

	assign cfg.ready = 1'b1;

	assign out_free     = !o_v_q || result.ready;
	assign cal_phase    = cal_cnt_q < CAL_DONE;
	assign cal_last     = cal_phase && (cal_cnt_q == CAL_LAST);
	assign s1_go        = s1_v && !fin_q && out_free;
	assign sample.ready = !s1_v || s1_go;
	assign o_load       = out_free && ((s1_go && !cal_last) || fin_q);

	// calibration sum
	assign sum_next = cal_sum_q + SUM_W'(smp_s1);

	// deadband test and tracking
	assign s8      = {smp_s1, 8'h00};
	assign d       = (BIAS_W+1)'(s8) - (BIAS_W+1)'(bias_q);
	assign d_x     = (BIAS_W+2)'(d);
	assign bw      = {2'b00, band_q, 8'h00};
	assign in_band = (d_x < bw) && (d_x > -bw);

	assign ema_p    = PROD_W'($signed({1'b0, weight_q})) * PROD_W'(d);
	assign ema_sh   = (ema_p + HALF) >>> FRAC_W;
	assign bias_sum = (BIAS_W+1)'(bias_q) + $signed(ema_sh[BIAS_W:0]);
	assign bias_trk = bias_sum[BIAS_W-1:0];

	assign rate_p  = PROD_W'($signed({1'b0, scale_q})) * PROD_W'(d);
	assign rate_sh = (rate_p + HALF) >>> FRAC_W;

	always_comb begin
		if (rate_sh > RATE_HI) begin
			rate_sat = RATE_HI[RATE_W-1:0];
		end else if (rate_sh < RATE_LO) begin
			rate_sat = RATE_LO[RATE_W-1:0];
		end else begin
			rate_sat = rate_sh[RATE_W-1:0];
		end
	end

	// rounded mean, halves away from zero
	assign sum_neg  = cal_sum_q[SUM_W-1];
	assign sum_mag  = sum_neg ? -cal_sum_q : cal_sum_q;
	assign div_x    = {sum_mag, 8'h00} + DIV_X_W'(CAL_SAMPLES / 2);
	assign div_p    = DIV_P_W'(div_x) * DIV_P_W'(DIV_M);
	assign div_q    = div_p[DIV_K +: BIAS_W];
	assign bias_cal = sum_neg ? -div_q : div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= BAND_RST;
			weight_q <= WEIGHT_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BAND: begin
					band_q <= cfg.data;
				end
				REG_WEIGHT: begin
					weight_q <= cfg.data;
				end
				REG_SCALE: begin
					scale_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v      <= 1'b0;
			fin_q     <= 1'b0;
			cal_cnt_q <= '0;
			cal_sum_q <= '0;
			bias_q    <= '0;
			o_v_q     <= 1'b0;
		end else begin
			if (sample.ready) begin
				s1_v <= sample.valid;
			end
			if (s1_go) begin
				if (cal_phase) begin
					cal_sum_q <= sum_next;
					cal_cnt_q <= cal_cnt_q + cnt_t'(1);
					if (cal_last) begin
						fin_q <= 1'b1;
					end
				end else if (in_band) begin
					bias_q <= bias_trk;
				end
			end
			if (fin_q && out_free) begin
				fin_q  <= 1'b0;
				bias_q <= bias_cal;
			end
			if (out_free) begin
				o_v_q <= o_load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1 <= sample.raw_sample;
		end
		if (o_load) begin
			if (fin_q) begin
				o_rate_q <= '0;
				o_held_q <= 1'b0;
				o_cal_q  <= 1'b1;
				o_bias_q <= bias_cal;
			end else if (cal_phase) begin
				o_rate_q <= '0;
				o_held_q <= 1'b0;
				o_cal_q  <= 1'b1;
				o_bias_q <= bias_q;
			end else if (in_band) begin
				o_rate_q <= '0;
				o_held_q <= 1'b1;
				o_cal_q  <= 1'b0;
				o_bias_q <= bias_trk;
			end else begin
				o_rate_q <= rate_sat;
				o_held_q <= 1'b0;
				o_cal_q  <= 1'b0;
				o_bias_q <= bias_q;
			end
		end
	end

	assign result.valid         = o_v_q;
	assign result.yaw_rate      = o_rate_q;
	assign result.held_zero     = o_held_q;
	assign result.calibrating   = o_cal_q;
	assign result.bias_estimate = o_bias_q;

	`GBDT_ASSERT_NEXT(a_cal_count_holds, clk, arst_n, cal_cnt_q == CAL_DONE,
		cal_cnt_q == CAL_DONE, "calibration count left its final value")
	`GBDT_ASSERT_IMPL(a_fin_after_last, clk, arst_n, fin_q,
		cal_cnt_q == CAL_DONE, "mean pending before all calibration samples")
	`GBDT_ASSERT_NEXT(a_fin_emits, clk, arst_n, fin_q && out_free,
		!fin_q && o_v_q && o_cal_q, "calibration result not issued")
	`GBDT_ASSERT_NEXT(a_bias_idle, clk, arst_n, !s1_go && !fin_q,
		$stable(bias_q), "bias changed without a sample")
	`GBDT_ASSERT_IMPL(a_held_zero_rate, clk, arst_n, o_v_q && o_held_q,
		o_rate_q == '0 && !o_cal_q, "held result with nonzero rate")

endmodule
